// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks, removed when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: src/hlp_pkg.sv
// ----------------------------------------------------------------------------
// hlp_pkg
// Types and constants shared by the header line parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package hlp_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [2:0] KIND_DROP     = 3'd0;
  localparam logic [2:0] KIND_NAME     = 3'd1;
  localparam logic [2:0] KIND_VALUE    = 3'd2;
  localparam logic [2:0] KIND_LINE_END = 3'd3;
  localparam logic [2:0] KIND_HDR_END  = 3'd4;
  localparam logic [2:0] KIND_BODY     = 3'd5;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    PH_NAME,
    PH_VALUE,
    PH_BODY
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_message;
  } hlp_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_out;
    logic        field_valid;
    logic [15:0] header_length;
    logic        last;
  } hlp_out_t;

  typedef struct packed {
    logic     two;
    hlp_out_t r0;
    hlp_out_t r1;
  } hlp_entry_t;

  typedef struct packed {
    logic                full;
    logic                empty;
    logic [QUEUE_AW:0]   count;
  } hlp_q_status_t;

endpackage

// File: src/hlp_front.sv
// ----------------------------------------------------------------------------
// hlp_front
// Accepts header bytes, tracks line state and builds up to two result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module hlp_front import hlp_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hlp_in_t       in_data,
  input  hlp_q_status_t q_status,
  output logic          push,
  output hlp_entry_t    push_entry
);

  function automatic logic [2:0] tag_kind(phase_t ph, logic vb, logic [7:0] b);
    logic [2:0] k;
    if (ph == PH_NAME) begin
      k = (b == CH_SPACE || b == CH_COLON) ? KIND_DROP : KIND_NAME;
    end else begin
      k = (b == CH_SPACE && !vb) ? KIND_DROP : KIND_VALUE;
    end
    return k;
  endfunction

  function automatic logic [7:0] tag_byte(phase_t ph, logic [7:0] b);
    logic [7:0] o;
    o = b;
    if (ph == PH_NAME && (b inside {[8'h41:8'h5A]})) begin
      o = b + 8'h20;
    end
    return o;
  endfunction

  phase_t                 ph_r, ph_nxt;
  logic                   crh_r, crh_nxt;
  logic                   lje_r, lje_nxt;
  logic                   cf_r, cf_nxt;
  logic                   vb_r, vb_nxt;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt;

  phase_t                 ph0, ph1, ph2;
  logic                   crh0, lje0, cf0, vb0, cf1, vb1, lje1, cf2, vb2;
  logic [LENGTH_BITS-1:0] cnt0, cnt1;
  logic [31:0]            cnt_ext;
  logic [15:0]            hdr_len;
  logic [7:0]             b;
  logic                   is_cr, is_lf, in_body, pair, cr_rel, accept;
  logic [1:0]             n;
  hlp_out_t               r0, r1;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.data_byte;
  assign is_cr    = (b == CH_CR);
  assign is_lf    = (b == CH_LF);

  always_comb begin
    ph0  = in_data.new_message ? PH_NAME : ph_r;
    crh0 = in_data.new_message ? 1'b0 : crh_r;
    lje0 = in_data.new_message ? 1'b0 : lje_r;
    cf0  = in_data.new_message ? 1'b0 : cf_r;
    vb0  = in_data.new_message ? 1'b0 : vb_r;
    cnt0 = in_data.new_message ? '0 : cnt_r;
    cnt1 = (cnt0 == '1) ? cnt0 : cnt0 + 1'b1;
    cnt_ext = 32'(cnt1);
    hdr_len = (cnt_ext > 32'h0000_FFFF) ? 16'hFFFF : cnt_ext[15:0];
    in_body = (ph0 == PH_BODY);
    pair    = !in_body && crh0 && is_lf;
    cr_rel  = !in_body && crh0 && !is_lf;
    ph1  = ph0;
    cf1  = cf0;
    vb1  = vb0 || (cr_rel && ph0 == PH_VALUE);
    lje1 = cr_rel ? 1'b0 : lje0;
    ph2  = (ph1 == PH_NAME && b == CH_COLON) ? PH_VALUE : ph1;
    cf2  = cf1 || (ph1 == PH_NAME && b == CH_COLON);
    vb2  = vb1 || (ph1 == PH_VALUE && !(b == CH_SPACE && !vb1));
  end

  always_comb begin
    ph_nxt  = ph0;
    crh_nxt = crh0;
    lje_nxt = lje0;
    cf_nxt  = cf0;
    vb_nxt  = vb0;
    cnt_nxt = cnt0;
    if (pair) begin
      cnt_nxt = cnt1;
      crh_nxt = 1'b0;
      cf_nxt  = 1'b0;
      vb_nxt  = 1'b0;
      ph_nxt  = lje0 ? PH_BODY : PH_NAME;
      lje_nxt = !lje0;
    end else if (!in_body) begin
      cnt_nxt = cnt1;
      if (is_cr) begin
        crh_nxt = 1'b1;
        ph_nxt  = ph1;
        cf_nxt  = cf1;
        vb_nxt  = vb1;
        lje_nxt = lje1;
      end else begin
        crh_nxt = 1'b0;
        ph_nxt  = ph2;
        cf_nxt  = cf2;
        vb_nxt  = vb2;
        lje_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    r0 = '0;
    r1 = '0;
    n  = 2'd0;
    if (in_body) begin
      r0.kind     = KIND_BODY;
      r0.byte_out = b;
      r0.last     = 1'b1;
      n           = 2'd1;
    end else if (pair) begin
      r0.byte_out = CH_LF;
      r0.last     = 1'b1;
      n           = 2'd1;
      if (lje0) begin
        r0.kind          = KIND_HDR_END;
        r0.header_length = hdr_len;
      end else begin
        r0.kind        = KIND_LINE_END;
        r0.field_valid = cf0 && vb0;
      end
    end else if (cr_rel) begin
      r0.kind     = tag_kind(ph0, vb0, CH_CR);
      r0.byte_out = tag_byte(ph0, CH_CR);
      if (is_cr) begin
        r0.last = 1'b1;
        n       = 2'd1;
      end else begin
        r1.kind     = tag_kind(ph1, vb1, b);
        r1.byte_out = tag_byte(ph1, b);
        r1.last     = 1'b1;
        n           = 2'd2;
      end
    end else if (!is_cr) begin
      r0.kind     = tag_kind(ph0, vb0, b);
      r0.byte_out = tag_byte(ph0, b);
      r0.last     = 1'b1;
      n           = 2'd1;
    end
  end

  assign push           = accept && (n != 2'd0);
  assign push_entry.two = (n == 2'd2);
  assign push_entry.r0  = r0;
  assign push_entry.r1  = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_NAME;
      crh_r <= 1'b0;
      lje_r <= 1'b0;
      cf_r  <= 1'b0;
      vb_r  <= 1'b0;
      cnt_r <= '0;
    end else if (accept) begin
      ph_r  <= ph_nxt;
      crh_r <= crh_nxt;
      lje_r <= lje_nxt;
      cf_r  <= cf_nxt;
      vb_r  <= vb_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: src/hlp_queue.sv
// ----------------------------------------------------------------------------
// hlp_queue
// Short FIFO of result entries between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module hlp_queue import hlp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hlp_entry_t    push_entry,
  input  logic          pop,
  output hlp_entry_t    head,
  output hlp_q_status_t status
);

  hlp_entry_t           mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wp_r, wp_nxt;
  logic [QUEUE_AW-1:0]  rp_r, rp_nxt;
  logic [QUEUE_AW:0]    cnt_r, cnt_nxt;

  assign head         = mem_r[rp_r];
  assign status.count = cnt_r;
  assign status.full  = (cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: src/hlp_back.sv
// ----------------------------------------------------------------------------
// hlp_back
// Drains queue entries one result word per cycle, while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module hlp_back import hlp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  hlp_entry_t    head,
  input  hlp_q_status_t q_status,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output hlp_out_t      out_data
);

  logic     out_valid_r, out_valid_nxt;
  hlp_out_t out_data_r, out_data_nxt;
  logic     idx_r, idx_nxt;
  logic     load, take;

  assign load = !out_valid_r || out_ready;
  assign take = load && !q_status.empty;
  assign pop  = take && (!head.two || idx_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = !q_status.empty;
    end
    if (take) begin
      out_data_nxt = idx_r ? head.r1 : head.r0;
      idx_nxt      = head.two && !idx_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: src/http_header_line_parser_core.sv
// ----------------------------------------------------------------------------
// http_header_line_parser_core
// Byte-wide HTTP header line splitter with tagged result words.
//
//   Port group  Dir  Handshake            Word
//   in_*        in   in_valid/in_ready    hlp_in_t (data_byte, new_message)
//   out_*       out  out_valid/out_ready  hlp_out_t (kind, byte, flags, length)
//
// One byte is taken per cycle while the four-entry result queue has room.
// A byte yields zero, one or two result words; the output drains one word
// per cycle while out_ready is high, so a stream of two-word bytes is held
// back by the output. A result word passes the queue, then the output register.
// Reset is synchronous on rst_n and clears parser state and the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module http_header_line_parser_core import hlp_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  hlp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output hlp_out_t out_data
);

  logic          push, pop;
  hlp_entry_t    push_entry, head;
  hlp_q_status_t q_status;

  hlp_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_entry(push_entry)
  );

  hlp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  hlp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  `ASSERT_IMPL(a_q_bound, clk, rst_n, 1'b1, q_status.count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
  `ASSERT_IMPL(a_no_pop_empty, clk, rst_n, q_status.empty, !pop)
  `ASSERT_IMPL(a_fv_line_end, clk, rst_n, out_valid && out_data.field_valid,
               out_data.kind == KIND_LINE_END)
  `ASSERT_IMPL(a_len_hdr_end, clk, rst_n, out_valid && out_data.kind != KIND_HDR_END,
               out_data.header_length == 16'd0)
  `ASSERT_NEXT(a_push_fills, clk, rst_n, push && !pop, !q_status.empty)

endmodule

// File: verif/header_split_checker.sv
// ----------------------------------------------------------------------------
// header_split_checker
// Watches both word channels of the header line parser. Predicts the tagged
// result words of every accepted byte from its own copy of the parser state,
// and compares each accepted result word field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module header_split_checker import hlp_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  hlp_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  hlp_out_t out_data,
  output int       mismatches,
  output int       due_count,
  output int       bytes_taken,
  output int       words_checked,
  output int       header_ends,
  output int       long_headers,
  output int       good_fields
);

  phase_t                 parse_at;
  logic                   cr_held;
  logic                   line_closed;
  logic                   colon_seen;
  logic                   value_seen;
  logic [LENGTH_BITS-1:0] hdr_bytes;

  hlp_out_t results_due [$];
  hlp_out_t due_word;
  int       fails;
  int       taken;
  int       checked;
  int       ends_seen;
  int       sat_seen;
  int       valid_seen;

  task automatic clear_parser();
    parse_at    = PH_NAME;
    cr_held     = 1'b0;
    line_closed = 1'b0;
    colon_seen  = 1'b0;
    value_seen  = 1'b0;
    hdr_bytes   = '0;
  endtask

  function automatic hlp_out_t tag_data(input logic [7:0] b);
    hlp_out_t r;
    r          = '0;
    r.byte_out = b;
    line_closed = 1'b0;
    if (parse_at == PH_NAME) begin
      if (b == CH_COLON) begin
        colon_seen = 1'b1;
        parse_at   = PH_VALUE;
        r.kind     = KIND_DROP;
      end else if (b == CH_SPACE) begin
        r.kind = KIND_DROP;
      end else begin
        r.kind = KIND_NAME;
        if (b >= "A" && b <= "Z") r.byte_out = b + 8'h20;
      end
    end else if (b == CH_SPACE && !value_seen) begin
      r.kind = KIND_DROP;
    end else begin
      value_seen = 1'b1;
      r.kind     = KIND_VALUE;
    end
    return r;
  endfunction

  task automatic split_header_byte(input hlp_in_t w);
    hlp_out_t words [$];
    hlp_out_t r;
    if (w.new_message) clear_parser();
    if (parse_at == PH_BODY) begin
      r          = '0;
      r.kind     = KIND_BODY;
      r.byte_out = w.data_byte;
      words.push_back(r);
    end else begin
      if (~&hdr_bytes) hdr_bytes = hdr_bytes + 1'b1;
      if (cr_held && w.data_byte == CH_LF) begin
        r          = '0;
        r.byte_out = CH_LF;
        if (line_closed) begin
          r.kind          = KIND_HDR_END;
          r.header_length = (32'(hdr_bytes) > 32'hFFFF) ? 16'hFFFF : 16'(hdr_bytes);
          parse_at        = PH_BODY;
          line_closed     = 1'b0;
          ends_seen++;
          if (r.header_length == 16'hFFFF) sat_seen++;
        end else begin
          r.kind        = KIND_LINE_END;
          r.field_valid = colon_seen && value_seen;
          line_closed   = 1'b1;
          parse_at      = PH_NAME;
          if (r.field_valid) valid_seen++;
        end
        cr_held    = 1'b0;
        colon_seen = 1'b0;
        value_seen = 1'b0;
        words.push_back(r);
      end else begin
        // release a held CR as data ahead of this byte
        if (cr_held) begin
          cr_held = 1'b0;
          words.push_back(tag_data(CH_CR));
        end
        if (w.data_byte == CH_CR) cr_held = 1'b1;
        else words.push_back(tag_data(w.data_byte));
      end
    end
    if (words.size() != 0) begin
      r      = words.pop_back();
      r.last = 1'b1;
      words.push_back(r);
    end
    foreach (words[i]) results_due.push_back(words[i]);
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      results_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        checked++;
        if (results_due.size() == 0) begin
          $error("result word with nothing due: kind %0d byte 0x%02h",
                 out_data.kind, out_data.byte_out);
          fails++;
        end else begin
          due_word = results_due.pop_front();
          check_field("kind", due_word.kind, out_data.kind);
          check_field("byte_out", due_word.byte_out, out_data.byte_out);
          check_field("field_valid", due_word.field_valid, out_data.field_valid);
          check_field("header_length", due_word.header_length, out_data.header_length);
          check_field("last", due_word.last, out_data.last);
        end
      end
      if (in_valid && in_ready) begin
        taken++;
        split_header_byte(in_data);
      end
    end
    mismatches    <= fails;
    due_count     <= results_due.size();
    bytes_taken   <= taken;
    words_checked <= checked;
    header_ends   <= ends_seen;
    long_headers  <= sat_seen;
    good_fields   <= valid_seen;
  end

endmodule

// File: verif/tb_http_header_line_parser_core.sv
// ----------------------------------------------------------------------------
// tb_http_header_line_parser_core
// Drives byte words into the header line parser: a directed run through the
// delimiter corner cases, then random well-formed headers mixed with broken
// ones and raw noise, and one long header with a single wide value.
// Both sides idle in random bursts; the receiver also stalls long once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_http_header_line_parser_core;
  import hlp_pkg::*;

  localparam int TARGET_WORDS = 1200;
  localparam int QUIET_FROM   = 1000;
  localparam int HOLD_AT      = 600;
  localparam int LONG_HOLD    = 300;
  localparam int LONG_BYTES   = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 1000000;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  hlp_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  hlp_out_t out_data;

  int mismatches;
  int due_count;
  int bytes_taken;
  int words_checked;
  int header_ends;
  int long_headers;
  int good_fields;

  int unsigned cycle_count = 0;
  int          words_sent  = 0;
  bit          idle_on     = 1'b1;
  bit          hold_req    = 1'b0;
  bit          hold_done   = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  http_header_line_parser_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  header_split_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .mismatches    (mismatches),
    .due_count     (due_count),
    .bytes_taken   (bytes_taken),
    .words_checked (words_checked),
    .header_ends   (header_ends),
    .long_headers  (long_headers),
    .good_fields   (good_fields)
  );

  task automatic push_word(input logic [7:0] b, input logic nm);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, new_message: nm};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  function automatic logic [7:0] name_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range("A", "Z"));
      4, 5, 6:    return 8'($urandom_range("a", "z"));
      7:          return 8'($urandom_range("0", "9"));
      8:          return "-";
      default:    return CH_SPACE;
    endcase
  endfunction

  task automatic send_message(input bit broken);
    logic [7:0] msg [$];
    int         lines;
    int         shape;
    int         cut;
    lines = $urandom_range(0, 5);
    for (int l = 0; l < lines; l++) begin
      shape = $urandom_range(0, 5);
      // shapes: 3 no colon, 4 empty name, 5 empty value
      if (shape != 4) repeat ($urandom_range(1, 8)) msg.push_back(name_char());
      if (shape != 3) msg.push_back(CH_COLON);
      repeat ($urandom_range(0, 3)) msg.push_back(CH_SPACE);
      if (shape != 5) begin
        repeat ($urandom_range(1, 10)) begin
          case ($urandom_range(0, 15))
            0: begin
              msg.push_back(CH_CR);
              msg.push_back(8'($urandom_range(8'h21, 8'h7E)));
            end
            1:       msg.push_back(CH_LF);
            default: msg.push_back(8'($urandom_range(8'h20, 8'h7E)));
          endcase
        end
      end
      msg.push_back(CH_CR);
      msg.push_back(CH_LF);
    end
    msg.push_back(CH_CR);
    msg.push_back(CH_LF);
    repeat ($urandom_range(0, 12)) msg.push_back(8'($urandom_range(0, 255)));
    cut = broken ? $urandom_range(1, msg.size()) : msg.size();
    for (int i = 0; i < cut; i++) push_word(msg[i], i == 0);
  endtask

  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 20)) begin
      case ($urandom_range(0, 7))
        0, 1:    b = CH_CR;
        2:       b = CH_LF;
        3:       b = CH_COLON;
        4:       b = CH_SPACE;
        default: b = 8'($urandom_range(0, 255));
      endcase
      push_word(b, $urandom_range(0, 15) == 0);
    end
  endtask

  task automatic send_long_header();
    push_word("x", 1'b1);
    push_word(CH_COLON, 1'b0);
    repeat (LONG_BYTES) push_word(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
    push_word(CH_CR, 1'b0);
    push_word(CH_LF, 1'b0);
    push_word(CH_CR, 1'b0);
    push_word(CH_LF, 1'b0);
    push_word("b", 1'b0);
  endtask

  // receiver side
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_http_header_line_parser_core: FAIL");
    $finish;
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // restart with a CR held, then a lone LF as the first byte
    push_word(CH_CR, 1'b1);
    push_word(CH_LF, 1'b1);
    // empty first line
    push_word(CH_CR, 1'b1);
    push_word(CH_LF, 1'b0);
    // name folding and letter bounds, spaces around the colon
    push_word("Z", 1'b0);
    push_word(CH_SPACE, 1'b0);
    push_word("@", 1'b0);
    push_word("[", 1'b0);
    push_word(CH_COLON, 1'b0);
    push_word(CH_SPACE, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(CH_SPACE, 1'b0);
    push_word(CH_CR, 1'b0);
    push_word("x", 1'b0);
    push_word(CH_CR, 1'b0);
    push_word(CH_LF, 1'b0);
    // empty name
    push_word(CH_COLON, 1'b0);
    push_word("v", 1'b0);
    push_word(CH_CR, 1'b0);
    push_word(CH_LF, 1'b0);
    // no colon, CR after CR
    push_word("n", 1'b0);
    push_word(CH_CR, 1'b0);
    push_word(CH_CR, 1'b0);
    push_word(CH_LF, 1'b0);
    // header end, then body bytes pass as they are
    push_word(CH_CR, 1'b0);
    push_word(CH_LF, 1'b0);
    push_word(CH_CR, 1'b0);
    push_word("A", 1'b0);

    while (words_sent < TARGET_WORDS) begin
      idle_on = (words_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      if (!hold_done && words_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_message($urandom_range(0, 7) == 0);
    end
    idle_on = 1'b0;
    send_long_header();

    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d byte words and %0d result words across directed, random",
             bytes_taken, words_checked);
    $display("and broken headers: %0d header ends (%0d saturated), %0d valid fields",
             header_ends, long_headers, good_fields);
    if (mismatches == 0) begin
      $display("tb_http_header_line_parser_core: PASS");
    end else begin
      $display("tb_http_header_line_parser_core: FAIL");
    end
    $finish;
  end

endmodule

// File: http_header_line_parser_core.f
+incdir+src
src/hlp_pkg.sv
src/hlp_front.sv
src/hlp_queue.sv
src/hlp_back.sv
src/http_header_line_parser_core.sv
verif/header_split_checker.sv
verif/tb_http_header_line_parser_core.sv
